/* rtl/core/lsqgc_pkg.sv */
`default_nettype none

package lsqgc_pkg;

  localparam int Slots        = 4;
  localparam int FacesPerCell = 4;

  localparam logic [30:0] WMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] nbr0_x;
    logic signed [31:0] nbr0_y;
    logic signed [31:0] nbr1_x;
    logic signed [31:0] nbr1_y;
    logic signed [31:0] nbr2_x;
    logic signed [31:0] nbr2_y;
    logic signed [31:0] nbr3_x;
    logic signed [31:0] nbr3_y;
  } in_item_t;

  typedef struct packed {
    logic        [30:0] weight0;
    logic        [30:0] weight1;
    logic        [30:0] weight2;
    logic        [30:0] weight3;
    logic signed [31:0] coef0_x;
    logic signed [31:0] coef0_y;
    logic signed [31:0] coef1_x;
    logic signed [31:0] coef1_y;
    logic signed [31:0] coef2_x;
    logic signed [31:0] coef2_y;
    logic signed [31:0] coef3_x;
    logic signed [31:0] coef3_y;
  } out_item_t;

  // clamp a signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sh0_7FFF_FFFF;
    lo = 36'shF_8000_0000;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/lsq_gradient_coefficients.sv */
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i   (cell center, neighbor points)
// out       output     out_valid_o / out_ready_i out_data_o  (weights, gradient vectors)
//
// one cell per cycle while the pipeline does not stall; a cell passes through the
// bit-per-stage inverse distance divider (64), square root (32) and coefficient
// dividers (31), plus the product and summing stages, to the output register.
// reset clears only the valid bits of the pipeline and the output register.
// the pipeline stalls only when its last stage holds a cell and the output
// register is full and not taken; with the last stage empty it keeps moving.
module lsq_gradient_coefficients #(
  parameter int FACES_PER_CELL = lsqgc_pkg::FacesPerCell
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lsqgc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lsqgc_pkg::out_item_t out_data_o
);

  localparam int Slots = lsqgc_pkg::Slots;

  logic en;
  logic last_vld;

  logic signed [31:0] nbr_x [Slots];
  logic signed [31:0] nbr_y [Slots];

  assign nbr_x[0] = in_data_i.nbr0_x;
  assign nbr_y[0] = in_data_i.nbr0_y;
  assign nbr_x[1] = in_data_i.nbr1_x;
  assign nbr_y[1] = in_data_i.nbr1_y;
  assign nbr_x[2] = in_data_i.nbr2_x;
  assign nbr_y[2] = in_data_i.nbr2_y;
  assign nbr_x[3] = in_data_i.nbr3_x;
  assign nbr_y[3] = in_data_i.nbr3_y;

  logic signed [33:0] txx [Slots];
  logic signed [33:0] txy [Slots];
  logic signed [33:0] tyy [Slots];
  logic signed [31:0] axx, axy, ayy;
  logic signed [63:0] det;

  logic        [30:0] wgt    [Slots];
  logic signed [31:0] cx     [Slots];
  logic signed [31:0] cy     [Slots];
  logic               c_vld  [Slots];

  for (genvar k = 0; k < Slots; k++) begin : g_slot
    if (k < FACES_PER_CELL) begin : g_lane
      logic               l_vld;
      logic        [30:0] l_w;
      logic signed [31:0] l_dx, l_dy;

      lsqgc_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .en_i       (en),
        .vld_i      (in_valid_i),
        .center_x_i (in_data_i.center_x),
        .center_y_i (in_data_i.center_y),
        .nbr_x_i    (nbr_x[k]),
        .nbr_y_i    (nbr_y[k]),
        .vld_o      (l_vld),
        .weight_o   (l_w),
        .dx_o       (l_dx),
        .dy_o       (l_dy),
        .txx_o      (txx[k]),
        .txy_o      (txy[k]),
        .tyy_o      (tyy[k])
      );

      lsqgc_coef u_coef (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .en_i     (en),
        .vld_i    (l_vld),
        .weight_i (l_w),
        .dx_i     (l_dx),
        .dy_i     (l_dy),
        .axx_i    (axx),
        .axy_i    (axy),
        .ayy_i    (ayy),
        .det_i    (det),
        .vld_o    (c_vld[k]),
        .weight_o (wgt[k]),
        .coef_x_o (cx[k]),
        .coef_y_o (cy[k])
      );
    end else begin : g_unused
      assign txx[k]   = '0;
      assign txy[k]   = '0;
      assign tyy[k]   = '0;
      assign wgt[k]   = '0;
      assign cx[k]    = '0;
      assign cy[k]    = '0;
      assign c_vld[k] = 1'b1;
    end
  end

  lsqgc_merge #(
    .FACES (FACES_PER_CELL)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .txx_i  (txx),
    .txy_i  (txy),
    .tyy_i  (tyy),
    .axx_o  (axx),
    .axy_o  (axy),
    .ayy_o  (ayy),
    .det_o  (det)
  );

  // all lanes move in lockstep, so their valid bits agree
  assign last_vld = c_vld[0] & c_vld[1] & c_vld[2] & c_vld[3];

  logic                 out_valid_q;
  logic                 out_valid_d;
  lsqgc_pkg::out_item_t out_data_q;
  lsqgc_pkg::out_item_t out_data_d;

  assign en         = !out_valid_q || out_ready_i || !last_vld;
  assign in_ready_o = en;

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || out_ready_i) begin
      out_valid_d = last_vld;
    end
  end

  always_comb begin
    out_data_d.weight0 = wgt[0];
    out_data_d.weight1 = wgt[1];
    out_data_d.weight2 = wgt[2];
    out_data_d.weight3 = wgt[3];
    out_data_d.coef0_x = cx[0];
    out_data_d.coef0_y = cy[0];
    out_data_d.coef1_x = cx[1];
    out_data_d.coef1_y = cy[1];
    out_data_d.coef2_x = cx[2];
    out_data_d.coef2_y = cy[2];
    out_data_d.coef3_x = cx[3];
    out_data_d.coef3_y = cy[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((!out_valid_q || out_ready_i) && last_vld) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/core/lsqgc_div_pipe.sv */
`default_nettype none

// restoring divider, one quotient bit per stage
module lsqgc_div_pipe #(
  parameter int QW = 31,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   r0_i,
  input  logic [63:0]   d_i,
  input  logic [QW-1:0] bits_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] side_o
);

  logic [63:0]   r_q [QW];
  logic [63:0]   d_q [QW];
  logic [QW-1:0] q_q [QW];
  logic [QW-1:0] b_q [QW];
  logic [SW-1:0] s_q [QW];
  logic          v_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [63:0]   r_in;
    logic [63:0]   d_in;
    logic [QW-1:0] q_in;
    logic [QW-1:0] b_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [63:0]   r_sh;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = r0_i;
      assign d_in = d_i;
      assign q_in = '0;
      assign b_in = bits_i;
      assign s_in = side_i;
      assign v_in = vld_i;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
      assign b_in = b_q[k-1];
      assign s_in = s_q[k-1];
      assign v_in = v_q[k-1];
    end

    assign r_sh = {r_in[62:0], b_in[QW-1]};
    assign ge   = (r_sh >= d_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? (r_sh - d_in) : r_sh;
        d_q[k] <= d_in;
        q_q[k] <= {q_in[QW-2:0], ge};
        b_q[k] <= b_in << 1;
        s_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = v_q[QW-1];
  assign q_o    = q_q[QW-1];
  assign side_o = s_q[QW-1];

endmodule

`default_nettype wire

/* rtl/core/lsqgc_isqrt_pipe.sv */
`default_nettype none

// floor square root of 64 bits, one root bit per stage
module lsqgc_isqrt_pipe #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   x_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [31:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int Steps = 32;

  logic [35:0]   rem_q  [Steps];
  logic [31:0]   root_q [Steps];
  logic [63:0]   x_q    [Steps];
  logic [SW-1:0] s_q    [Steps];
  logic          v_q    [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_stage
    logic [35:0]   rem_in;
    logic [31:0]   root_in;
    logic [63:0]   x_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [35:0]   rem_sh;
    logic [35:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign s_in    = side_i;
      assign v_in    = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign s_in    = s_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign rem_sh = {rem_in[33:0], x_in[63:62]};
    assign trial  = {2'b00, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[30:0], ge};
        x_q[k]    <= x_in << 2;
        s_q[k]    <= s_in;
      end
    end
  end

  assign vld_o  = v_q[Steps-1];
  assign root_o = root_q[Steps-1];
  assign side_o = s_q[Steps-1];

endmodule

`default_nettype wire

/* rtl/core/lsqgc_lane.sv */
`default_nettype none

// one face: offset, inverse distance weight and weighted normal matrix terms
module lsqgc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] nbr_x_i,
  input  logic signed [31:0] nbr_y_i,
  output logic               vld_o,
  output logic        [30:0] weight_o,
  output logic signed [31:0] dx_o,
  output logic signed [31:0] dy_o,
  output logic signed [33:0] txx_o,
  output logic signed [33:0] txy_o,
  output logic signed [33:0] tyy_o
);

  localparam int SideW = 65;

  // offsets
  logic signed [32:0] dx_full, dy_full;
  logic signed [31:0] dx1_q, dy1_q;
  logic               v1_q;

  assign dx_full = 33'(nbr_x_i) - 33'(center_x_i);
  assign dy_full = 33'(nbr_y_i) - 33'(center_y_i);

  // squares
  logic signed [63:0] sqx, sqy;
  logic        [63:0] sqx_q, sqy_q;
  logic signed [31:0] dx2_q, dy2_q;
  logic               v2_q;

  assign sqx = dx1_q * dx1_q;
  assign sqy = dy1_q * dy1_q;

  // squared distance
  logic [63:0]        d2_q;
  logic               small_q;
  logic signed [31:0] dx3_q, dy3_q;
  logic               v3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q   <= lsqgc_pkg::sat_s32(36'(dx_full));
      dy1_q   <= lsqgc_pkg::sat_s32(36'(dy_full));
      sqx_q   <= sqx;
      sqy_q   <= sqy;
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      d2_q    <= sqx_q + sqy_q;
      small_q <= ((sqx_q + sqy_q) <= 64'd1);
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
    end
  end

  // 2^64 / d2, then square root
  logic             dv_vld;
  logic [63:0]      dv_q;
  logic [SideW-1:0] dv_side;

  lsqgc_div_pipe #(
    .QW (64),
    .SW (SideW)
  ) u_inv_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v3_q),
    .r0_i   (64'd1),
    .d_i    (d2_q),
    .bits_i ('0),
    .side_i ({small_q, dx3_q, dy3_q}),
    .vld_o  (dv_vld),
    .q_o    (dv_q),
    .side_o (dv_side)
  );

  logic             sq_vld;
  logic [31:0]      sq_root;
  logic [SideW-1:0] sq_side;

  lsqgc_isqrt_pipe #(
    .SW (SideW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (dv_vld),
    .x_i    (dv_q),
    .side_i (dv_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // weight, saturated for tiny distances
  logic        [30:0] w_q;
  logic signed [31:0] dxw_q, dyw_q;
  logic               vw_q;

  // weighted offsets
  logic signed [63:0] pwx, pwy;
  logic signed [63:0] pwx_q, pwy_q;
  logic        [30:0] wp_q;
  logic signed [31:0] dxp_q, dyp_q;
  logic               vp_q;

  assign pwx = $signed({1'b0, w_q}) * dxw_q;
  assign pwy = $signed({1'b0, w_q}) * dyw_q;

  // |a|, |b| stay within 2^16 since w * |dx| <= 2^32
  logic signed [17:0] a, b;
  logic signed [49:0] pxx, pxy, pyy;
  logic signed [49:0] pxx_q, pxy_q, pyy_q;
  logic        [30:0] wo_q;
  logic signed [31:0] dxo_q, dyo_q;
  logic               vo_q;

  assign a   = pwx_q[33:16];
  assign b   = pwy_q[33:16];
  assign pxx = a * dxp_q;
  assign pxy = a * dyp_q;
  assign pyy = b * dyp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q   <= (sq_side[SideW-1] || sq_root[31]) ? lsqgc_pkg::WMax : sq_root[30:0];
      dxw_q <= sq_side[63:32];
      dyw_q <= sq_side[31:0];
      pwx_q <= pwx;
      pwy_q <= pwy;
      wp_q  <= w_q;
      dxp_q <= dxw_q;
      dyp_q <= dyw_q;
      pxx_q <= pxx;
      pxy_q <= pxy;
      pyy_q <= pyy;
      wo_q  <= wp_q;
      dxo_q <= dxp_q;
      dyo_q <= dyp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vw_q <= 1'b0;
      vp_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vw_q <= sq_vld;
      vp_q <= vw_q;
      vo_q <= vp_q;
    end
  end

  assign vld_o    = vo_q;
  assign weight_o = wo_q;
  assign dx_o     = dxo_q;
  assign dy_o     = dyo_q;
  assign txx_o    = pxx_q[49:16];
  assign txy_o    = pxy_q[49:16];
  assign tyy_o    = pyy_q[49:16];

endmodule

`default_nettype wire

/* rtl/core/lsqgc_merge.sv */
`default_nettype none

// sums the lane terms into the normal matrix and forms its determinant
module lsqgc_merge #(
  parameter int FACES = lsqgc_pkg::FacesPerCell
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [33:0] txx_i [lsqgc_pkg::Slots],
  input  logic signed [33:0] txy_i [lsqgc_pkg::Slots],
  input  logic signed [33:0] tyy_i [lsqgc_pkg::Slots],
  output logic signed [31:0] axx_o,
  output logic signed [31:0] axy_o,
  output logic signed [31:0] ayy_o,
  output logic signed [63:0] det_o
);

  logic signed [35:0] sxx, sxy, syy;
  logic signed [31:0] axx_q, axy_q, ayy_q;
  logic signed [63:0] pa, pb;
  logic signed [63:0] pa_q, pb_q;
  logic signed [63:0] det_q;

  always_comb begin
    sxx = '0;
    sxy = '0;
    syy = '0;
    for (int k = 0; k < FACES; k++) begin
      sxx = sxx + 36'(txx_i[k]);
      sxy = sxy + 36'(txy_i[k]);
      syy = syy + 36'(tyy_i[k]);
    end
  end

  assign pa = axx_q * ayy_q;
  assign pb = axy_q * axy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      axx_q <= lsqgc_pkg::sat_s32(sxx);
      axy_q <= lsqgc_pkg::sat_s32(sxy);
      ayy_q <= lsqgc_pkg::sat_s32(syy);
      pa_q  <= pa;
      pb_q  <= pb;
      det_q <= pa_q - pb_q;
    end
  end

  assign axx_o = axx_q;
  assign axy_o = axy_q;
  assign ayy_o = ayy_q;
  assign det_o = det_q;

endmodule

`default_nettype wire

/* rtl/core/lsqgc_coef.sv */
`default_nettype none

// one face: numerators, two dividers by the determinant, saturation
module lsqgc_coef (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic        [30:0] weight_i,
  input  logic signed [31:0] dx_i,
  input  logic signed [31:0] dy_i,
  input  logic signed [31:0] axx_i,
  input  logic signed [31:0] axy_i,
  input  logic signed [31:0] ayy_i,
  input  logic signed [63:0] det_i,
  output logic               vld_o,
  output logic        [30:0] weight_o,
  output logic signed [31:0] coef_x_o,
  output logic signed [31:0] coef_y_o
);

  localparam int QW    = 31;
  localparam int SideW = 34;

  logic        [30:0] w1_q, w2_q, w3_q, w4_q;
  logic signed [31:0] dx1_q, dy1_q;
  logic               v1_q, v2_q, v3_q, v4_q;

  // products against the matrix entries
  logic signed [63:0] p_ax, p_bx, p_ay, p_by;
  logic signed [63:0] p_ax_q, p_bx_q, p_ay_q, p_by_q;

  assign p_ax = ayy_i * dx1_q;
  assign p_bx = axy_i * dy1_q;
  assign p_ay = axx_i * dy1_q;
  assign p_by = axy_i * dx1_q;

  logic signed [63:0] nx_q, ny_q;

  // magnitudes, overflow check and divider start values
  logic [63:0] nax, nay, dab;
  logic        ovfx, ovfy;

  assign nax  = nx_q[63] ? 64'(-nx_q) : 64'(nx_q);
  assign nay  = ny_q[63] ? 64'(-ny_q) : 64'(ny_q);
  assign dab  = det_i[63] ? 64'(-det_i) : 64'(det_i);
  assign ovfx = ({15'b0, nax} >= {dab, 15'b0});
  assign ovfy = ({15'b0, nay} >= {dab, 15'b0});

  logic [63:0]   r0x_q, r0y_q, d_q;
  logic [QW-1:0] bx_q, by_q;
  logic          negx_q, negy_q, ovfx_q, ovfy_q, zero_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q   <= weight_i;
      dx1_q  <= dx_i;
      dy1_q  <= dy_i;
      w2_q   <= w1_q;
      p_ax_q <= p_ax;
      p_bx_q <= p_bx;
      p_ay_q <= p_ay;
      p_by_q <= p_by;
      w3_q   <= w2_q;
      nx_q   <= p_ax_q - p_bx_q;
      ny_q   <= p_ay_q - p_by_q;
      w4_q   <= w3_q;
      r0x_q  <= {15'b0, nax[63:15]};
      r0y_q  <= {15'b0, nay[63:15]};
      bx_q   <= {nax[14:0], 16'b0};
      by_q   <= {nay[14:0], 16'b0};
      d_q    <= dab;
      negx_q <= nx_q[63] ^ det_i[63];
      negy_q <= ny_q[63] ^ det_i[63];
      ovfx_q <= ovfx;
      ovfy_q <= ovfy;
      zero_q <= (det_i == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  logic             qx_vld;
  logic [QW-1:0]    qx, qy;
  logic [SideW-1:0] sx;
  logic [1:0]       sy;

  lsqgc_div_pipe #(
    .QW (QW),
    .SW (SideW)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v4_q),
    .r0_i   (r0x_q),
    .d_i    (d_q),
    .bits_i (bx_q),
    .side_i ({w4_q, negx_q, ovfx_q, zero_q}),
    .vld_o  (qx_vld),
    .q_o    (qx),
    .side_o (sx)
  );

  lsqgc_div_pipe #(
    .QW (QW),
    .SW (2)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (v4_q),
    .r0_i   (r0y_q),
    .d_i    (d_q),
    .bits_i (by_q),
    .side_i ({negy_q, ovfy_q}),
    .vld_o  (),
    .q_o    (qy),
    .side_o (sy)
  );

  logic signed [31:0] qxs, qys;
  logic               zero;

  assign qxs  = $signed({1'b0, qx});
  assign qys  = $signed({1'b0, qy});
  assign zero = sx[0];

  always_comb begin
    if (zero) begin
      coef_x_o = '0;
      coef_y_o = '0;
    end else begin
      if (sx[1]) begin
        coef_x_o = sx[2] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        coef_x_o = sx[2] ? -qxs : qxs;
      end
      if (sy[0]) begin
        coef_y_o = sy[1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        coef_y_o = sy[1] ? -qys : qys;
      end
    end
  end

  assign vld_o    = qx_vld;
  assign weight_o = sx[SideW-1:3];

endmodule

`default_nettype wire
